[design/mplcf_pkg.sv]
// Package for the multi-pipe line-commit FIFO unit: sizes, codes, item types
// and small pointer helpers.
// No dependencies.
package mplcf_pkg;

    // Sizing
    localparam int NUM_PIPES  = 8;
    localparam int RING_DEPTH = 256;
    localparam int JOBQ_DEPTH = 2;

    localparam int BYTE_W    = 8;
    localparam int SEL_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int REF_W     = 2;
    localparam int PTR_W     = $clog2(RING_DEPTH);
    localparam int PIDX_W    = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int RAM_DEPTH = NUM_PIPES * RING_DEPTH;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    // Constants of the protocol
    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [REF_W-1:0]  FULL_REFS    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CLOSED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOPIPE = 3'd4;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_ALLOC = 2'd2,
        CMD_CLOSE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [SEL_W-1:0]  pipe_sel;
        logic [BYTE_W-1:0] wr_byte;
        logic              call_last;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   rd_byte;
        logic [SEL_W-1:0]    pipe_out;
        logic                last_out;
    } out_item_t;

    // Decoded operation handed from front to back
    typedef struct packed {
        cmd_t              op;
        logic              sel_ok;
        logic [PIDX_W-1:0] pidx;
        logic [BYTE_W-1:0] wr_byte;
        logic              is_newline;
        logic              call_last;
    } job_t;

    function automatic logic [PTR_W-1:0] ptr_wrap(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [RAM_AW-1:0] ring_addr(input logic [PIDX_W-1:0] pidx,
                                                    input logic [PTR_W-1:0] ptr);
        return RAM_AW'(pidx) * RAM_AW'(RING_DEPTH) + RAM_AW'(ptr);
    endfunction

endpackage

[design/mplcf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mplcf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/mplcf_front.sv]
// Front end: accepts items, decodes them into jobs, buffers them in a short queue.
// Depends on mplcf_pkg.
module mplcf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mplcf_pkg::in_item_t item,
    output logic                job_valid,
    output mplcf_pkg::job_t     job,
    input  logic                job_take
);
    import mplcf_pkg::*;

    localparam int JQ_PW = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
    localparam int JQ_CW = $clog2(JOBQ_DEPTH + 1);

    job_t             job_q_reg [JOBQ_DEPTH];
    logic [JQ_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JQ_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JQ_CW-1:0] count_reg, count_next;
    job_t             new_job;
    logic             push_acc;

    function automatic logic [JQ_PW-1:0] q_wrap(input logic [JQ_PW-1:0] p);
        return (p == JQ_PW'(JOBQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // decode
    always_comb
    begin
        new_job.op         = cmd_t'(item.cmd);
        new_job.sel_ok     = (int'(item.pipe_sel) < NUM_PIPES);
        new_job.pidx       = PIDX_W'(item.pipe_sel);
        new_job.wr_byte    = item.wr_byte;
        new_job.is_newline = (item.wr_byte == NEWLINE_BYTE);
        new_job.call_last  = item.call_last;
    end

    assign full      = (count_reg == JQ_CW'(JOBQ_DEPTH));
    assign push_acc  = push && !full;
    assign job_valid = (count_reg != '0);
    assign job       = job_q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_acc ? q_wrap(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = job_take ? q_wrap(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + JQ_CW'(push_acc) - JQ_CW'(job_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            job_q_reg[wr_ptr_reg] <= new_job;
        end
    end

endmodule

[design/mplcf_back.sv]
// Back end: per-pipe pointers and reference counts, the ring RAM, and the
// one-entry result register. Depends on mplcf_pkg and mplcf_ram.
module mplcf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  mplcf_pkg::job_t      job,
    output logic                 job_take,
    input  logic                 pop,
    output logic                 empty,
    output mplcf_pkg::out_item_t result
);
    import mplcf_pkg::*;

    typedef enum logic [1:0] {
        BK_EXEC   = 2'b01,
        BK_RDWAIT = 2'b10
    } bk_state_t;

    bk_state_t        state_reg, state_next;
    logic [PTR_W-1:0] read_pos_reg   [NUM_PIPES];
    logic [PTR_W-1:0] read_pos_next  [NUM_PIPES];
    logic [PTR_W-1:0] fill_pos_reg   [NUM_PIPES];
    logic [PTR_W-1:0] fill_pos_next  [NUM_PIPES];
    logic [PTR_W-1:0] commit_pos_reg [NUM_PIPES];
    logic [PTR_W-1:0] commit_pos_next[NUM_PIPES];
    logic [REF_W-1:0] ref_cnt_reg    [NUM_PIPES];
    logic [REF_W-1:0] ref_cnt_next   [NUM_PIPES];
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;
    logic             pend_last_reg, pend_last_next;

    logic              go, pop_acc, produce;
    out_item_t         res;
    logic [PTR_W-1:0]  cur_rd, cur_fill, cur_commit, fill_adv;
    logic [REF_W-1:0]  cur_ref;
    logic              free_found;
    logic [PIDX_W-1:0] free_idx;
    logic              any_ref_over;

    logic              ram_we, ram_re;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    mplcf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (job.wr_byte),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign pop_acc  = pop && out_valid_reg;
    assign go       = (state_reg == BK_EXEC) && job_valid && (!out_valid_reg || pop);
    assign job_take = go;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    assign cur_rd     = read_pos_reg[job.pidx];
    assign cur_fill   = fill_pos_reg[job.pidx];
    assign cur_commit = commit_pos_reg[job.pidx];
    assign cur_ref    = ref_cnt_reg[job.pidx];
    assign fill_adv   = ptr_wrap(cur_fill);
    assign ram_waddr  = ring_addr(job.pidx, cur_fill);
    assign ram_raddr  = ring_addr(job.pidx, cur_rd);

    // lowest free pipe
    always_comb
    begin
        free_found   = 1'b0;
        free_idx     = '0;
        any_ref_over = 1'b0;
        for (int i = NUM_PIPES - 1; i >= 0; i--)
        begin
            if (ref_cnt_reg[i] == '0)
            begin
                free_found = 1'b1;
                free_idx   = PIDX_W'(i);
            end
            if (ref_cnt_reg[i] > FULL_REFS)
            begin
                any_ref_over = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        read_pos_next   = read_pos_reg;
        fill_pos_next   = fill_pos_reg;
        commit_pos_next = commit_pos_reg;
        ref_cnt_next    = ref_cnt_reg;
        pend_last_next  = pend_last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        produce         = 1'b0;
        res.status      = ST_OK;
        res.rd_byte     = '0;
        res.pipe_out    = '0;
        res.last_out    = job.call_last;

        case (state_reg)
            BK_EXEC:
            begin
                if (go)
                begin
                    produce = 1'b1;
                    case (job.op)
                        CMD_WRITE:
                        begin
                            if (!job.sel_ok || fill_adv == cur_rd)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we                  = 1'b1;
                                fill_pos_next[job.pidx] = fill_adv;
                                if (job.is_newline)
                                begin
                                    commit_pos_next[job.pidx] = fill_adv;
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            if (!job.sel_ok)
                            begin
                                res.status = ST_CLOSED;
                            end
                            else if (cur_rd == cur_commit)
                            begin
                                res.status = (cur_ref < FULL_REFS) ? ST_CLOSED : ST_EMPTY;
                            end
                            else
                            begin
                                // byte comes back from the RAM next cycle
                                produce                 = 1'b0;
                                ram_re                  = 1'b1;
                                read_pos_next[job.pidx] = ptr_wrap(cur_rd);
                                pend_last_next          = job.call_last;
                                state_next              = BK_RDWAIT;
                            end
                        end
                        CMD_ALLOC:
                        begin
                            if (free_found)
                            begin
                                read_pos_next[free_idx]   = '0;
                                fill_pos_next[free_idx]   = '0;
                                commit_pos_next[free_idx] = '0;
                                ref_cnt_next[free_idx]    = FULL_REFS;
                                res.pipe_out              = SEL_W'(free_idx);
                            end
                            else
                            begin
                                res.status = ST_NOPIPE;
                            end
                        end
                        CMD_CLOSE:
                        begin
                            if (job.sel_ok && cur_ref != '0)
                            begin
                                ref_cnt_next[job.pidx] = cur_ref - 1'b1;
                            end
                        end
                        default:
                        begin
                            produce = 1'b1;
                        end
                    endcase
                end
            end
            BK_RDWAIT:
            begin
                produce      = 1'b1;
                res.status   = ST_OK;
                res.rd_byte  = ram_rdata;
                res.last_out = pend_last_reg;
                state_next   = BK_EXEC;
            end
            default:
            begin
                state_next = BK_EXEC;
            end
        endcase

        out_valid_next = (out_valid_reg && !pop_acc) || produce;
        out_next       = produce ? res : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_EXEC;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PIPES; i++)
            begin
                read_pos_reg[i]   <= '0;
                fill_pos_reg[i]   <= '0;
                commit_pos_reg[i] <= '0;
                ref_cnt_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            read_pos_reg   <= read_pos_next;
            fill_pos_reg   <= fill_pos_next;
            commit_pos_reg <= commit_pos_next;
            ref_cnt_reg    <= ref_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg       <= out_next;
        pend_last_reg <= pend_last_next;
    end

    // The result slot is kept free while a read waits on the RAM.
    a_rdwait_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_RDWAIT |-> !out_valid_reg)
        else $error("result slot occupied during RAM read");

    a_rdwait_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_RDWAIT |=> out_valid_reg && state_reg == BK_EXEC)
        else $error("pending read did not deliver a result");

    a_no_take_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> state_reg == BK_EXEC && job_valid)
        else $error("job taken while back end busy or queue empty");

    a_ref_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !any_ref_over)
        else $error("reference count above two");

    a_ram_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("ring RAM written and read by one job");

endmodule

[design/multi_pipe_line_commit_fifo_unit.sv]
// Top level of the multi-pipe line-commit FIFO unit: front decode queue plus
// back end execution. Depends on mplcf_pkg, mplcf_front, mplcf_back.
//
// A bank of NUM_PIPES byte pipes, each a ring of RING_DEPTH bytes in one shared
// RAM, with read, fill and commit pointers and a two-bit reference count per
// pipe. Each input transfer is one operation (write byte, read byte, allocate,
// close) and yields exactly one result transfer, in order. A write that brings
// a newline commits all bytes written so far; reads only see committed bytes.
// Both sides behave as queues: push/full accept operations into a two-entry
// decode queue, empty/pop deliver results from a one-entry result register.
// Write, allocate and close complete in the back end's execute state; a
// successful read also passes through a read-wait state, since the ring RAM
// has a registered read port and the byte is captured into the result
// register from the RAM's read data in that read-wait state. The back end
// only starts an operation when the result register is free or being popped
// in the same cycle, so a stalled consumer backs up into the decode queue
// and then asserts full.
// Pointer and reference state comes out of reset cleared; ring contents are
// undefined until written and need no clearing pass.
module multi_pipe_line_commit_fifo_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  mplcf_pkg::in_item_t  item,
    output logic                 empty,
    input  logic                 pop,
    output mplcf_pkg::out_item_t result
);
    import mplcf_pkg::*;

    logic job_valid;
    logic job_take;
    job_t job;

    // Decode and buffer incoming operations
    mplcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    // Execute against pipe state and ring RAM, hold the result
    mplcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule
